// ===== design/lcd_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU cache directory package
// Shared widths, register codes and the lookup result record used by the
// directory, the counters and the top level.
// ----------------------------------------------------------------------------
package lcd_pkg;

  // Fixed field widths of the ports
  localparam int KEY_TAG_W = 32;
  localparam int SLOT_W    = 4;
  localparam int CNT_W     = 32;
  localparam int CAP_W     = 5;

  // Configuration port geometry: one 32-bit register at byte address 0
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int REG_W  = 1;

  // Register index codes
  localparam logic [REG_W-1:0] REG_CAPACITY = 1'b0;

  // Default sizing of the directory
  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 32;

  // Counter saturation value
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Outcome of one lookup, as it leaves the directory
  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 stored;
    logic                 evicted;
    logic [KEY_TAG_W-1:0] evicted_key;
  } lookup_t;

endpackage

// ===== design/lcd_cfg.sv =====
// ----------------------------------------------------------------------------
// LRU cache directory configuration register
// APB-style slave holding the capacity register. A write to it also raises
// a one-cycle clear for the table and the counters.
// ----------------------------------------------------------------------------
module lcd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcd_pkg::ADDR_W-1:0]  paddr,
  input  logic [lcd_pkg::DATA_W-1:0]  pwdata,
  output logic [lcd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [lcd_pkg::CAP_W-1:0]   capacity,
  output logic                        clear
);
  import lcd_pkg::*;

  logic             wr_en;
  logic [REG_W-1:0] reg_idx;

  // The register index is the word address; the byte offset is ignored.
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_W];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign clear   = wr_en && (reg_idx == REG_CAPACITY);

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (clear) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CAPACITY) begin
      prdata = DATA_W'(capacity);
    end
  end

endmodule

// ===== design/lcd_dir.sv =====
// ----------------------------------------------------------------------------
// LRU cache directory entry array
// Holds the keys, valid bits and recency ages of all entries, compares a key
// against every entry in parallel and applies the LRU update when update is set.
// ----------------------------------------------------------------------------
module lcd_dir #(
  parameter int ENTRIES  = lcd_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lcd_pkg::DEF_KEY_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       update,
  input  logic [KEY_BITS-1:0]        key,
  input  logic [lcd_pkg::CAP_W-1:0]  capacity,
  output lcd_pkg::lookup_t           res
);
  import lcd_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W = IDX_W;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [KEY_BITS-1:0] entry_keys [ENTRIES];
  logic [ENTRIES-1:0]  entry_valid;
  logic [AGE_W-1:0]    entry_age [ENTRIES];
  logic [OCC_W-1:0]    occupancy;

  logic [ENTRIES-1:0]  match;
  logic [ENTRIES-1:0]  free_vec;
  logic [ENTRIES-1:0]  free_oh;
  logic [ENTRIES-1:0]  victim_oh;
  logic [ENTRIES-1:0]  target_oh;
  logic [ENTRIES-1:0]  age_inc;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    victim_idx;
  logic [IDX_W-1:0]    target_idx;
  logic [AGE_W-1:0]    hit_age;
  logic [AGE_W-1:0]    oldest_age;
  logic [KEY_BITS-1:0] victim_key;
  logic [OCC_W-1:0]    occ_m1;
  logic [CMP_W-1:0]    cap_req;
  logic [CMP_W-1:0]    cap_eff;
  logic                enabled;
  logic                any_match;
  logic                has_room;
  logic                do_hit;
  logic                do_fill;
  logic                do_evict;

  // Effective capacity is the register value limited to the array depth.
  assign cap_req  = CMP_W'(capacity);
  assign cap_eff  = (cap_req > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_req;
  assign enabled  = (capacity != '0);
  assign has_room = (CMP_W'(occupancy) < cap_eff);

  // Ages of valid entries form 0 .. occupancy-1, so the oldest is unique.
  assign occ_m1     = occupancy - 1'b1;
  assign oldest_age = AGE_W'(occ_m1);

  // Lowest free slot as a one-hot vector
  assign free_vec = ~entry_valid;
  assign free_oh  = free_vec & (~free_vec + 1'b1);

  // Parallel compare, victim search and index encoding
  always_comb begin
    match      = '0;
    victim_oh  = '0;
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    hit_age    = '0;
    victim_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = entry_valid[i] && (entry_keys[i] == key);
      victim_oh[i] = entry_valid[i] && (entry_age[i] == oldest_age);
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_age = hit_age | entry_age[i];
      end
      if (free_oh[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
      if (victim_oh[i]) begin
        victim_idx = victim_idx | IDX_W'(i);
        victim_key = victim_key | entry_keys[i];
      end
    end
  end

  assign any_match = |match;
  assign do_hit    = enabled && any_match;
  assign do_fill   = enabled && !any_match && has_room;
  assign do_evict  = enabled && !any_match && !has_room;

  // Slot that receives or keeps the key
  always_comb begin
    if (do_hit) begin
      target_oh  = match;
      target_idx = hit_idx;
    end else if (do_fill) begin
      target_oh  = free_oh;
      target_idx = free_idx;
    end else begin
      target_oh  = victim_oh;
      target_idx = victim_idx;
    end
  end

  // Entries that grow one step older on this lookup
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_hit) begin
        age_inc[i] = entry_valid[i] && (entry_age[i] < hit_age);
      end else if (do_fill) begin
        age_inc[i] = entry_valid[i];
      end else begin
        age_inc[i] = entry_valid[i] && !victim_oh[i];
      end
    end
  end

  // Result record
  always_comb begin
    res             = '0;
    res.hit         = do_hit;
    res.stored      = enabled;
    res.evicted     = do_evict;
    res.slot        = enabled ? SLOT_W'(target_idx) : '0;
    res.evicted_key = do_evict ? KEY_TAG_W'(victim_key) : '0;
  end

  // Valid bits, ages and fill count
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      entry_valid <= '0;
      occupancy   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_age[i] <= '0;
      end
    end else if (update && enabled) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (target_oh[i]) begin
          entry_age[i]   <= '0;
          entry_valid[i] <= 1'b1;
        end else if (age_inc[i]) begin
          entry_age[i] <= entry_age[i] + 1'b1;
        end
      end
      if (do_fill) begin
        occupancy <= occupancy + 1'b1;
      end
    end
  end

  // Key store; entries are only read while valid, so no reset is needed.
  always_ff @(posedge clk) begin
    if (update && enabled && !any_match) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (target_oh[i]) begin
          entry_keys[i] <= key;
        end
      end
    end
  end

  // Stored keys are unique, so at most one entry can match.
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("more than one directory entry matches the key");

  // The fill count tracks the number of valid entries.
  a_occ_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(occupancy))
    else $error("occupancy differs from the number of valid entries");

  // An eviction always finds exactly one least recently used entry.
  a_victim_found: assert property (@(posedge clk) disable iff (rst)
    (update && do_evict) |-> $onehot(victim_oh))
    else $error("eviction without a unique oldest entry");

endmodule

// ===== design/lcd_cnt.sv =====
// ----------------------------------------------------------------------------
// LRU cache directory statistics counters
// Saturating hit and miss counters. The totals after the current lookup are
// offered combinationally for the result register.
// ----------------------------------------------------------------------------
module lcd_cnt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       count_en,
  input  logic                       hit,
  output logic [lcd_pkg::CNT_W-1:0]  hit_total_next,
  output logic [lcd_pkg::CNT_W-1:0]  miss_total_next
);
  import lcd_pkg::*;

  logic [CNT_W-1:0] hit_counter;
  logic [CNT_W-1:0] miss_counter;

  // Totals including the current lookup
  assign hit_total_next  = (hit && hit_counter != CNT_MAX) ?
                           hit_counter + 1'b1 : hit_counter;
  assign miss_total_next = (!hit && miss_counter != CNT_MAX) ?
                           miss_counter + 1'b1 : miss_counter;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hit_counter  <= '0;
      miss_counter <= '0;
    end else if (count_en) begin
      hit_counter  <= hit_total_next;
      miss_counter <= miss_total_next;
    end
  end

endmodule

// ===== design/lru_cache_directory_top.sv =====
// ----------------------------------------------------------------------------
// LRU cache directory
// Fully associative directory of lookup tags with least recently used
// replacement, saturating hit and miss statistics and a capacity register.
//
//   Channel   Direction  Handshake          Payload
//   -------   ---------  -----------------  ---------------------------------
//   in        sink       in_valid/in_stall  key_tag
//   out       source     out_valid/out_stall hit, slot, stored, evicted,
//                                           evicted_key, hit_total, miss_total
//   cfg       APB slave  psel/penable/pready capacity at byte address 0
//
// A word accepted on the input is held in the input register, then the
// directory compare and LRU update run combinationally into the result
// register; one word per cycle is sustained while the output is not stalled.
// The parallel tag compare across all entries sets the cycle time.
// Reset clears the table, counters and capacity at once; no clearing pass.
// An output stall holds the result register and stalls the input only when
// the input register is also full.
// ----------------------------------------------------------------------------
module lru_cache_directory_top #(
  parameter int ENTRIES  = lcd_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lcd_pkg::DEF_KEY_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lcd_pkg::ADDR_W-1:0]     paddr,
  input  logic [lcd_pkg::DATA_W-1:0]     pwdata,
  output logic [lcd_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lcd_pkg::KEY_TAG_W-1:0]  key_tag,
  // Output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic [lcd_pkg::SLOT_W-1:0]     slot,
  output logic                           stored,
  output logic                           evicted,
  output logic [lcd_pkg::KEY_TAG_W-1:0]  evicted_key,
  output logic [lcd_pkg::CNT_W-1:0]      hit_total,
  output logic [lcd_pkg::CNT_W-1:0]      miss_total
);
  import lcd_pkg::*;

  logic                 in_full;
  logic [KEY_TAG_W-1:0] key_q;
  logic                 in_take;
  logic                 advance;
  logic                 out_free;
  logic                 clear;
  logic [CAP_W-1:0]     capacity;
  lookup_t              res;
  logic [CNT_W-1:0]     hit_total_next;
  logic [CNT_W-1:0]     miss_total_next;

  // Handshake: the result register frees when empty or being taken.
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_full && out_free;
  assign in_stall = in_full && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Configuration register
  lcd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity),
    .clear    (clear)
  );

  // Entry array and LRU update
  lcd_dir #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dir (
    .clk      (clk),
    .rst      (rst),
    .clear    (clear),
    .update   (advance),
    .key      (KEY_BITS'(key_q)),
    .capacity (capacity),
    .res      (res)
  );

  // Hit and miss statistics
  lcd_cnt u_cnt (
    .clk             (clk),
    .rst             (rst),
    .clear           (clear),
    .count_en        (advance),
    .hit             (res.hit),
    .hit_total_next  (hit_total_next),
    .miss_total_next (miss_total_next)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      key_q <= key_tag;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit         <= res.hit;
      slot        <= res.slot;
      stored      <= res.stored;
      evicted     <= res.evicted;
      evicted_key <= res.evicted_key;
      hit_total   <= hit_total_next;
      miss_total  <= miss_total_next;
    end
  end

  // A lookup is processed only when the result register can take it.
  a_advance_room: assert property (@(posedge clk) disable iff (rst)
    advance |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  // An eviction always leaves the new key stored and is never a hit.
  a_evict_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> (stored && !hit))
    else $error("inconsistent eviction result");

  // A lookup that reaches the result register frees the input register.
  a_input_drains: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_take) |=> !in_full)
    else $error("input register not released after a lookup");

endmodule

// ===== sim/lru_cache_directory_top_tb.sv =====
// ----------------------------------------------------------------------------
// LRU cache directory testbench
// Sends lookup keys through the directory under several capacity settings,
// from disabled through clamped-to-full, and checks every result word against
// an in-bench model of the tag table, its recency ages and its counters.
// Both channels idle and stall at random; one phase runs with no idling, one
// holds the output off long enough to back the block up to its input.
// ----------------------------------------------------------------------------
module lru_cache_directory_top_tb;
  import lcd_pkg::*;

  localparam int ENTRY_COUNT = DEF_ENTRIES;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam logic [ADDR_W-1:0] CAP_ADDR    = {REG_CAPACITY, 2'b00};
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = 3'd4;

  // Expected outcome of one lookup, counters included
  typedef struct packed {
    lookup_t          res;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
  } lookup_expect_t;

  // Scoreboard: keeps its own copy of the directory and predicts each result.
  class lookup_scoreboard;
    logic [KEY_TAG_W-1:0] tag_store [ENTRY_COUNT];
    bit                   tag_valid [ENTRY_COUNT];
    int unsigned          tag_age   [ENTRY_COUNT];
    int unsigned          fill_count;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
    logic [CAP_W-1:0]     capacity;
    lookup_expect_t       pending_lookups [$];
    int                   errors;
    int                   checked;
    int                   seen_hits;

    function new();
      capacity = '0;
      errors   = 0;
      checked  = 0;
      seen_hits = 0;
      clear_table();
    endfunction

    function void clear_table();
      int i;
      for (i = 0; i < ENTRY_COUNT; i++) begin
        tag_store[i] = '0;
        tag_valid[i] = 1'b0;
        tag_age[i]   = 0;
      end
      fill_count = 0;
      hits       = '0;
      misses     = '0;
    endfunction

    function void write_capacity(logic [CAP_W-1:0] value);
      capacity = value;
      clear_table();
    endfunction

    // Every valid entry younger than the limit grows one step older.
    function void age_younger(int unsigned limit);
      int i;
      for (i = 0; i < ENTRY_COUNT; i++)
        if (tag_valid[i] && tag_age[i] < limit) tag_age[i]++;
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Note an accepted key word and work out the result it must produce.
    function void note_lookup(logic [KEY_TAG_W-1:0] key);
      lookup_expect_t e;
      int found;
      int target;
      int eff_cap;
      int i;
      int unsigned oldest;
      e       = '0;
      found   = -1;
      target  = -1;
      oldest  = 0;
      eff_cap = (capacity > ENTRY_COUNT) ? ENTRY_COUNT : int'(capacity);
      for (i = 0; i < ENTRY_COUNT; i++)
        if (found < 0 && tag_valid[i] && tag_store[i] == key) found = i;

      if (eff_cap == 0) begin
        // Disabled: a counted miss and nothing stored.
        misses = bump(misses);
      end else if (found >= 0) begin
        e.res.hit    = 1'b1;
        e.res.stored = 1'b1;
        e.res.slot   = found[SLOT_W-1:0];
        age_younger(tag_age[found]);
        tag_age[found] = 0;
        hits = bump(hits);
      end else begin
        misses = bump(misses);
        if (fill_count < eff_cap)
          for (i = 0; i < ENTRY_COUNT; i++)
            if (target < 0 && !tag_valid[i]) target = i;
        if (target >= 0) begin
          age_younger(32'hFFFF_FFFF);
          fill_count++;
        end else begin
          // Table full: replace the least recently used entry.
          for (i = 0; i < ENTRY_COUNT; i++)
            if (tag_valid[i] && (target < 0 || tag_age[i] > oldest)) begin
              target = i;
              oldest = tag_age[i];
            end
          if (target < 0) target = 0;
          e.res.evicted     = 1'b1;
          e.res.evicted_key = tag_store[target];
          age_younger(oldest);
        end
        tag_store[target] = key;
        tag_valid[target] = 1'b1;
        tag_age[target]   = 0;
        e.res.stored = 1'b1;
        e.res.slot   = target[SLOT_W-1:0];
      end
      e.hit_total  = hits;
      e.miss_total = misses;
      pending_lookups.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_lookup(logic h, logic [SLOT_W-1:0] s, logic st, logic ev,
                               logic [KEY_TAG_W-1:0] ek, logic [CNT_W-1:0] ht,
                               logic [CNT_W-1:0] mt);
      lookup_expect_t e;
      if (pending_lookups.size() == 0) begin
        $error("result word with no lookup outstanding");
        errors++;
        return;
      end
      e = pending_lookups.pop_front();
      checked++;
      if (e.res.hit) seen_hits++;
      compare_field("hit", 32'(e.res.hit), 32'(h));
      compare_field("slot", 32'(e.res.slot), 32'(s));
      compare_field("stored", 32'(e.res.stored), 32'(st));
      compare_field("evicted", 32'(e.res.evicted), 32'(ev));
      compare_field("evicted_key", e.res.evicted_key, ek);
      compare_field("hit_total", e.hit_total, ht);
      compare_field("miss_total", e.miss_total, mt);
    endfunction
  endclass

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [ADDR_W-1:0]    paddr     = '0;
  logic [DATA_W-1:0]    pwdata    = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [KEY_TAG_W-1:0] key_tag   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 hit;
  logic [SLOT_W-1:0]    slot;
  logic                 stored;
  logic                 evicted;
  logic [KEY_TAG_W-1:0] evicted_key;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     miss_total;

  lookup_scoreboard     sb;
  logic [KEY_TAG_W-1:0] key_pool [$];
  bit                   calm      = 1'b0;
  bit                   hold_req  = 1'b0;
  bit                   hold_done = 1'b0;
  int                   hold_left = 0;
  int                   cycle_count = 0;
  int                   settings_run = 0;

  int phase_cap   [PHASES] = '{16, 1, 31, 5, 0, 20, 3, 16};
  int phase_items [PHASES] = '{150, 80, 120, 120, 40, 120, 100, 150};

  lru_cache_directory_top dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .key_tag     (key_tag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .slot        (slot),
    .stored      (stored),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .hit_total   (hit_total),
    .miss_total  (miss_total)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_cache_directory_top: mismatch");
      $finish;
    end
  end

  // Receiver: take result words, stall at random, and hold off once for a
  // long stretch when asked.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_lookup(hit, slot, stored, evicted, evicted_key, hit_total, miss_total);
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 24);
    end
  end

  // Offer one key word, idling at random first, and return once accepted.
  task automatic send_key(logic [KEY_TAG_W-1:0] key);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    key_tag  <= key;
    do @(posedge clk); while (in_stall);
    sb.note_lookup(key);
  endtask

  // Stop sending and wait for every outstanding result to come back.
  task automatic drain(int settle);
    in_valid <= 1'b0;
    while (sb.pending_lookups.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // One configuration-port transfer: setup cycle, then access until ready.
  task automatic reg_access(bit wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register, mirror it in the scoreboard and read capacity back.
  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd;
    reg_access(1'b1, addr, data, rd);
    if (addr[ADDR_W-1:2] == REG_CAPACITY) begin
      sb.write_capacity(data[CAP_W-1:0]);
      settings_run++;
    end
    reg_access(1'b0, CAP_ADDR, '0, rd);
    sb.compare_field("capacity", 32'(sb.capacity), rd);
  endtask

  // Build a pool of keys a little larger than the table, with near neighbours
  // that differ in a single bit, so that hits and evictions both come often.
  task automatic fill_pool(int cap);
    int eff;
    int n;
    int k;
    eff = (cap > ENTRY_COUNT) ? ENTRY_COUNT : cap;
    n   = eff + 2 + $urandom_range(3);
    key_pool.delete();
    for (k = 0; k < n; k++)
      if (k > 0 && $urandom_range(3) == 0)
        key_pool.push_back(key_pool[$urandom_range(k - 1)] ^ (32'd1 << $urandom_range(31)));
      else
        key_pool.push_back($urandom);
  endtask

  function automatic logic [KEY_TAG_W-1:0] pick_key();
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(key_pool.size() - 1)];
    return $urandom;
  endfunction

  initial begin
    int p;
    int n;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: disabled after reset, then a two-entry table with
    // replacement in both orders and a neighbouring key one bit away.
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    drain(4);
    write_reg(CAP_ADDR, 32'd2);
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    send_key(32'h5A5A_5A5A);
    send_key(32'hFFFF_FFFF);
    send_key(32'h5A5A_5A5A);
    send_key(32'h0000_0001);
    send_key(32'h0000_0001);
    drain(4);
    // A write outside the register map must leave the table alone.
    write_reg(UNUSED_ADDR, 32'd0);
    send_key(32'h0000_0001);
    send_key(32'h5A5A_5A5A);
    send_key(32'hA5A5_A5A5);
    drain(4);

    // Random phases over a spread of capacities, extremes included.
    for (p = 0; p < PHASES; p++) begin
      write_reg(CAP_ADDR, 32'(phase_cap[p]));
      fill_pool(phase_cap[p]);
      calm     = (p == 0);
      hold_req = (p == 2);
      for (n = 0; n < phase_items[p]; n++) begin
        send_key(pick_key());
        // Midway through the held phase the sender waits for the backlog.
        if (p == 2 && n == phase_items[p] / 2) drain(0);
      end
      drain(4);
    end
    calm = 1'b0;

    drain(10);
    $display("Covered %0d lookups, %0d of them hits, over %0d capacity settings.",
             sb.checked, sb.seen_hits, settings_run);
    if (sb.errors == 0 && sb.pending_lookups.size() == 0) begin
      $display("lru_cache_directory_top: match");
    end else begin
      $display("lru_cache_directory_top: mismatch");
    end
    $finish;
  end

endmodule
